/* rtl/rtpfu_pkg.sv */
// Shared types and constants for the RTP H.264 FU-A packetizer.
// Used by rtpfu_seq and rtp_h264_fua_packetizer_core; depends on nothing.
`default_nettype none

package rtpfu_pkg;

   localparam int unsigned RTP_HDR_BYTES = 12;
   localparam logic [4:0]  FU_A_TYPE     = 5'd28;
   localparam logic [10:0] FRAG_MIN      = 11'd1100;
   localparam logic [10:0] FRAG_MAX      = 11'd1460;

   // prefix_kind codes, also the number of prefix bytes
   localparam logic [1:0] PFX_NONE = 2'd0;
   localparam logic [1:0] PFX_NAL  = 2'd1;
   localparam logic [1:0] PFX_FU   = 2'd2;

   // register indexes on the csr port
   localparam logic [2:0] REG_SSRC     = 3'd0;
   localparam logic [2:0] REG_TS_INC   = 3'd1;
   localparam logic [2:0] REG_VIDEO_PT = 3'd2;
   localparam logic [2:0] REG_AUDIO_PT = 3'd3;
   localparam logic [2:0] REG_MAX_FRAG = 3'd4;

   localparam logic       MODE_AAC = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [15:0] unit_length;
      logic [7:0]  nal_header;
   } req_type;

   typedef struct packed {
      logic [15:0] sequence_number;
      logic [31:0] packet_timestamp;
      logic        marker_bit;
      logic [6:0]  payload_type;
      logic [1:0]  prefix_kind;
      logic [7:0]  prefix_first;
      logic [7:0]  prefix_second;
      logic [15:0] data_offset;
      logic [15:0] data_length;
      logic [16:0] packet_length;
      logic        last_of_unit;
   } rsp_type;

   typedef struct packed {
      logic [16:0] ts_increment;
      logic [6:0]  video_payload_type;
      logic [6:0]  audio_payload_type;
      logic [10:0] max_fragment;
   } cfg_type;

endpackage

`default_nettype wire

/* rtl/rtpfu_seq.sv */
// Packet sequencer: latches one unit, then walks its fragments one packet per step
// through a shared subtract/compare unit. Depends on rtpfu_pkg.
`default_nettype none

module rtpfu_seq
   import rtpfu_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    start,
   input  wire req_type unit,
   input  wire logic    take,
   output logic         busy,
   output logic         pkt_valid,
   output rsp_type      pkt
);

   typedef enum logic {S_IDLE, S_WORK} state_type;

   state_type   state_ff, state_in;
   logic [15:0] seq_ff, seq_in;
   logic [31:0] ts_ff, ts_in;
   logic        mode_ff, mode_in;
   logic [7:0]  hdr_ff, hdr_in;
   logic [1:0]  kind_ff, kind_in;
   logic [10:0] frag_ff, frag_in;
   logic [15:0] off_ff, off_in;
   logic [15:0] rem_ff, rem_in;
   logic        first_ff, first_in;

   logic [10:0] frag_clamped;
   logic [16:0] diff;
   logic        gt;
   logic        last;
   logic [15:0] chunk;
   logic        emit;

   always_comb begin
      frag_clamped = cfg.max_fragment;
      if (cfg.max_fragment < FRAG_MIN) begin
         frag_clamped = FRAG_MIN;
      end else if (cfg.max_fragment > FRAG_MAX) begin
         frag_clamped = FRAG_MAX;
      end
   end

   // shared unit: remaining minus fragment size, sign and zero give the compare
   assign diff  = {1'b0, rem_ff} - {6'd0, frag_ff};
   assign gt    = !diff[16] && (diff[15:0] != 16'd0);
   assign last  = (kind_ff != PFX_FU) || !gt;
   assign chunk = last ? rem_ff : {5'd0, frag_ff};
   assign emit  = (state_ff == S_WORK) && take;

   assign busy      = (state_ff != S_IDLE);
   assign pkt_valid = emit;

   always_comb begin
      pkt.sequence_number  = seq_ff;
      pkt.packet_timestamp = ts_ff;
      pkt.marker_bit       = last;
      pkt.payload_type     = (mode_ff == MODE_AAC) ? cfg.audio_payload_type
                                                   : cfg.video_payload_type;
      pkt.prefix_kind      = kind_ff;
      pkt.data_offset      = off_ff;
      pkt.data_length      = chunk;
      pkt.packet_length    = 17'(RTP_HDR_BYTES) + {15'd0, kind_ff} + {1'b0, chunk};
      pkt.last_of_unit     = last;
      case (kind_ff)
         PFX_NAL: begin
            pkt.prefix_first  = hdr_ff;
            pkt.prefix_second = 8'd0;
         end
         PFX_FU: begin
            pkt.prefix_first  = {hdr_ff[7:5], FU_A_TYPE};
            pkt.prefix_second = {first_ff, last, 1'b0, hdr_ff[4:0]};
         end
         default: begin
            pkt.prefix_first  = 8'd0;
            pkt.prefix_second = 8'd0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      seq_in   = seq_ff;
      ts_in    = ts_ff;
      mode_in  = mode_ff;
      hdr_in   = hdr_ff;
      kind_in  = kind_ff;
      frag_in  = frag_ff;
      off_in   = off_ff;
      rem_in   = rem_ff;
      first_in = first_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_WORK;
               ts_in    = ts_ff + {15'd0, cfg.ts_increment};
               mode_in  = unit.mode;
               hdr_in   = unit.nal_header;
               frag_in  = frag_clamped;
               first_in = 1'b1;
               if (unit.mode == MODE_AAC) begin
                  kind_in = PFX_NONE;
                  off_in  = 16'd0;
                  rem_in  = unit.unit_length;
               end else if (unit.unit_length <= {5'd0, frag_clamped}) begin
                  kind_in = PFX_NAL;
                  off_in  = 16'd1;
                  rem_in  = (unit.unit_length != 16'd0) ? unit.unit_length - 16'd1
                                                        : 16'd0;
               end else begin
                  kind_in = PFX_FU;
                  off_in  = 16'd1;
                  rem_in  = unit.unit_length - 16'd1;
               end
            end
         end
         S_WORK: begin
            if (emit) begin
               seq_in   = seq_ff + 16'd1;
               off_in   = off_ff + chunk;
               rem_in   = diff[15:0];
               first_in = 1'b0;
               if (last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         seq_ff   <= 16'd0;
         ts_ff    <= 32'd0;
         kind_ff  <= PFX_NONE;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         seq_ff   <= seq_in;
         ts_ff    <= ts_in;
         kind_ff  <= kind_in;
         first_ff <= first_in;
      end
      mode_ff <= mode_in;
      hdr_ff  <= hdr_in;
      frag_ff <= frag_in;
      off_ff  <= off_in;
      rem_ff  <= rem_in;
   end

endmodule

`default_nettype wire

/* rtl/rtp_h264_fua_packetizer_core.sv */
// Top level of the RTP H.264 FU-A / AAC packetizer: csr registers, sequencer, result register.
// Depends on rtpfu_pkg and rtpfu_seq.
//
//   channel  prefix  direction  word
//   input    req_    in         req_type: one media unit descriptor
//   result   rsp_    out        rsp_type: one RTP packet descriptor
//   config   csr_    in/out     APB-style, 32-bit registers at 4*index
//
// A unit is taken while the sequencer is idle, then the sequencer emits one packet per
// cycle, unless rsp_stall pauses it, through its subtract/compare unit.
// req_stall stays high until the last packet of the unit has entered the
// result register; rsp_stall holds that register and pauses the sequencer.
// Synchronous active-high reset clears the counters and loads register defaults.
`default_nettype none

module rtp_h264_fua_packetizer_core
   import rtpfu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [31:0] ssrc_ff;
   cfg_type     cfg_ff;
   logic        wr_en;
   logic [2:0]  reg_idx;

   logic        busy;
   logic        take;
   logic        pkt_valid;
   rsp_type     pkt;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ssrc_ff                   <= 32'd10;
         cfg_ff.ts_increment       <= 17'd3600;
         cfg_ff.video_payload_type <= 7'd96;
         cfg_ff.audio_payload_type <= 7'd97;
         cfg_ff.max_fragment       <= 11'd1400;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_SSRC:     ssrc_ff                   <= csr_pwdata;
            REG_TS_INC:   cfg_ff.ts_increment       <= csr_pwdata[16:0];
            REG_VIDEO_PT: cfg_ff.video_payload_type <= csr_pwdata[6:0];
            REG_AUDIO_PT: cfg_ff.audio_payload_type <= csr_pwdata[6:0];
            REG_MAX_FRAG: cfg_ff.max_fragment       <= csr_pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SSRC:     csr_prdata = ssrc_ff;
         REG_TS_INC:   csr_prdata = {15'd0, cfg_ff.ts_increment};
         REG_VIDEO_PT: csr_prdata = {25'd0, cfg_ff.video_payload_type};
         REG_AUDIO_PT: csr_prdata = {25'd0, cfg_ff.audio_payload_type};
         REG_MAX_FRAG: csr_prdata = {21'd0, cfg_ff.max_fragment};
         default:      csr_prdata = 32'd0;
      endcase
   end

   assign req_stall = busy;
   assign take      = !rsp_valid_ff || !rsp_stall;

   rtpfu_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .start     (req_valid && !busy),
      .unit      (req_data),
      .take      (take),
      .busy      (busy),
      .pkt_valid (pkt_valid),
      .pkt       (pkt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= pkt_valid;
      end
      if (take && pkt_valid) begin
         rsp_data_ff <= pkt;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
